// File: sv/cpma_pkg.sv
// Shared types and constants for the capture period moving average block.
package cpma_pkg;

  localparam int unsigned CAPTURE_W = 16;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [CAPTURE_W-1:0] tick_t;

  // Result item fields, highest bit first.
  typedef struct packed {
    logic [OUT_DATA_W-CAPTURE_W-CAPTURE_W-2:0] pad;
    logic                                      average_valid;
    tick_t                                     average_period;
    tick_t                                     period;
  } result_t;

endpackage

// File: sv/capture_period_moving_average.sv
// Top level: edge period measurement with a moving average over a ring of periods.
//
// Input channel s_*: one item per captured rising edge, the 16-bit timer value.
// Output channel m_*: exactly one item per input item, in order, carrying the
// period since the previous capture (modulo 2^16), the truncated mean of the
// last WINDOW periods and a flag that goes high once WINDOW periods have been
// seen. Until then the mean reads zero. The first period is taken from zero.
//
// One item is taken every cycle unless the output is stalled: the ring
// sits in a single-port memory with one registered read, each entry is read and
// overwritten in the cycle the item is accepted, and the running total is
// updated from the registered read data. The divide by WINDOW is a reciprocal
// multiply in stage 3 and a one-step correction ahead of the stage 4 register.
//
// Reset (rst, synchronous) clears the capture history, total, ring position
// and fill flag; ring entries need no clearing since an entry is subtracted
// only after the window has filled. When m_tready is low, results hold in the
// output register and the pipeline keeps taking items until each stage is full.
module capture_period_moving_average #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cpma_pkg::CAPTURE_W-1:0]  s_tdata,  // [15:0] capture_value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cpma_pkg::OUT_DATA_W-1:0] m_tdata   // [15:0] period,
                                                    // [31:16] average_period,
                                                    // [32] average_valid, [39:33] zero
);
  import cpma_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW);
  localparam int unsigned TOTAL_W = CAPTURE_W + $clog2(WINDOW);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(WINDOW * ((1 << CAPTURE_W) - 1));

  tick_t ring [WINDOW];

  // Accept-side state.
  tick_t             previous_capture;
  logic [POS_W-1:0]  ring_position;
  logic              window_filled;
  logic              accept;
  tick_t             period_new;

  // Stage 1: ring read data.
  logic  v1, f1, old_valid1;
  tick_t period1, old1;
  // Stage 2: running total.
  logic  v2, f2;
  tick_t period2;
  logic [TOTAL_W-1:0] running_total;
  // Stage 3: product in the divider.
  logic  v3, f3;
  tick_t period3;
  tick_t quotient;
  // Stage 4: output register.
  logic    v4;
  result_t result;

  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept = s_tvalid && s_tready;
  assign period_new = s_tdata - previous_capture;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_capture <= '0;
      ring_position    <= '0;
      window_filled    <= 1'b0;
    end else if (accept) begin
      previous_capture <= s_tdata;
      if (ring_position == LAST_POS) begin
        ring_position <= '0;
        window_filled <= 1'b1;
      end else begin
        ring_position <= ring_position + POS_W'(1);
      end
    end
  end

  // Read-before-write ring access.
  always_ff @(posedge clk) begin
    if (accept) begin
      old1                <= ring[ring_position];
      ring[ring_position] <= period_new;
      period1             <= period_new;
      old_valid1          <= window_filled;
      f1                  <= window_filled || (ring_position == LAST_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      running_total <= '0;
    end else begin
      if (rdy1) begin
        v1 <= accept;
      end
      if (rdy2) begin
        v2 <= v1;
        if (v1) begin
          running_total <= running_total - (old_valid1 ? TOTAL_W'(old1) : '0)
                           + TOTAL_W'(period1);
        end
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      period2 <= period1;
      f2      <= f1;
    end
    if (rdy3 && v2) begin
      period3 <= period2;
      f3      <= f2;
    end
    if (rdy4 && v3) begin
      result.pad            <= '0;
      result.period         <= period3;
      result.average_period <= f3 ? quotient : '0;
      result.average_valid  <= f3;
    end
  end

  cpma_cdiv #(
    .WINDOW (WINDOW),
    .TOTAL_W(TOTAL_W)
  ) u_cdiv (
    .clk     (clk),
    .load    (rdy3 && v2),
    .dividend(running_total),
    .quotient(quotient)
  );

  assign m_tvalid = v4;
  assign m_tdata  = result;

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    running_total <= TOTAL_MAX)
    else $error("running total beyond window maximum");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_position <= LAST_POS)
    else $error("ring position out of range");

  a_fill_sticky: assert property (@(posedge clk) disable iff (rst)
    window_filled |=> window_filled)
    else $error("fill flag dropped");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.average_valid) |-> (result.average_period == '0))
    else $error("average non-zero before window filled");

  a_wrap_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && ring_position == LAST_POS) |=> window_filled)
    else $error("ring wrap did not set fill flag");

endmodule

// File: sv/cpma_cdiv.sv
// Two-step divide by the window length: reciprocal multiply, then one correction.
module cpma_cdiv #(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned TOTAL_W = 20
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic [TOTAL_W-1:0]             dividend,
  output logic [cpma_pkg::CAPTURE_W-1:0] quotient
);
  import cpma_pkg::*;

  localparam logic [TOTAL_W-1:0] RECIP = TOTAL_W'((64'd1 << TOTAL_W) / WINDOW);
  localparam logic [TOTAL_W-1:0] DIVISOR = TOTAL_W'(WINDOW);

  logic [2*TOTAL_W-1:0] product;
  logic [TOTAL_W-1:0]   dividend_q;
  tick_t                q_est;
  logic [TOTAL_W-1:0]   remainder;

  always_ff @(posedge clk) begin
    if (load) begin
      product    <= dividend * RECIP;
      dividend_q <= dividend;
    end
  end

  // Estimate is low by at most one.
  always_comb begin
    q_est     = CAPTURE_W'(product[2*TOTAL_W-1:TOTAL_W]);
    remainder = dividend_q - TOTAL_W'(TOTAL_W'(q_est) * DIVISOR);
    quotient  = (remainder >= DIVISOR) ? q_est + tick_t'(1) : q_est;
  end

endmodule

// File: tb/sv/capture_period_moving_average_tb.sv
// Testbench for capture_period_moving_average: directed table, then random captures vs predictor.
module capture_period_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpma_pkg::*;

  localparam int unsigned WINDOW = 10;
  localparam int unsigned RANDOM_CAPTURES = 1425;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct {
    tick_t       capture;
    bit          typed;
    tick_t       want_period;
    tick_t       want_average;
    logic        want_valid;
  } edge_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [CAPTURE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  tick_t        last_capture;
  tick_t        period_history [WINDOW];
  logic [19:0]  period_sum;
  int unsigned  slot;
  logic         window_full;
  tick_t        mean_hold;

  result_t      expected_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           quiet = 1'b0;

  // edges: zero start, extremes, wrap, equal captures, window of
  // full-scale periods, then a window of zero periods
  edge_row_t edge_table [25] = '{
    '{16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 1'b0},
    '{16'h0000, 1'b1, 16'h0001, 16'h0000, 1'b0},
    '{16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0},
    '{16'h8000, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FFE, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FFD, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FFC, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FFB, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FFA, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF9, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF8, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF7, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{16'h7FF6, 1'b1, 16'h0000, 16'h0000, 1'b1}
  };

  capture_period_moving_average DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] capture_value
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [15:0] period, [31:16] average_period, [32] average_valid
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  function automatic result_t predict_measurement(tick_t capture);
    result_t r;
    tick_t   p;
    p = capture - last_capture;
    last_capture = capture;
    if (slot >= WINDOW) slot = 0;
    period_sum = period_sum - 20'(period_history[slot]) + 20'(p);
    period_history[slot] = p;
    slot++;
    if (slot >= WINDOW) begin
      slot = 0;
      window_full = 1'b1;
    end
    if (window_full) mean_hold = tick_t'(period_sum / WINDOW);
    r = '0;
    r.period = p;
    r.average_period = mean_hold;
    r.average_valid = window_full;
    return r;
  endfunction

  task automatic send_capture(input tick_t value, input bit typed, input result_t typed_result);
    result_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_measurement(value);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic maybe_idle_sender();
    if (!quiet && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // receiver back-pressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: no item expected, actual %h", $time, m_tdata);
      end else begin
        want = expected_results.pop_front();
        compare_field("period", want.period, got.period);
        compare_field("average_period", want.average_period, got.average_period);
        compare_field("average_valid", want.average_valid, got.average_valid);
        compare_field("pad", want.pad, got.pad);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("capture_period_moving_average_tb failed");
        $finish;
      end
    end
  end

  initial begin
    result_t     typed_result;
    tick_t       capture;
    tick_t       typical_period;
    int unsigned pick;

    last_capture = '0;
    foreach (period_history[i]) period_history[i] = '0;
    period_sum = '0;
    slot = 0;
    window_full = 1'b0;
    mean_hold = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_table[i]) begin
      typed_result = '0;
      typed_result.period = edge_table[i].want_period;
      typed_result.average_period = edge_table[i].want_average;
      typed_result.average_valid = edge_table[i].want_valid;
      send_capture(edge_table[i].capture, edge_table[i].typed, typed_result);
      maybe_idle_sender();
    end
    hold_until_drained();

    capture = last_capture;
    typical_period = tick_t'($urandom_range(2000, 1));
    for (int unsigned n = 0; n < RANDOM_CAPTURES; n++) begin
      quiet = (n >= RANDOM_CAPTURES - QUIET_TAIL) || ((n / 100) % 4 == 3);
      if ($urandom_range(49) == 0) typical_period = tick_t'($urandom);
      pick = $urandom_range(9);
      case (pick)
        0, 1: capture = tick_t'($urandom);
        2: ;
        3, 4, 5: capture = capture + typical_period + tick_t'($urandom_range(15));
        6, 7: capture = capture + tick_t'($urandom_range(65535, 60000));
        8: capture = capture - tick_t'($urandom_range(16, 1));
        default: capture = capture + tick_t'($urandom_range(255));
      endcase
      send_capture(capture, 1'b0, '0);
      if (n == RANDOM_CAPTURES / 2) hold_until_drained();
      else maybe_idle_sender();
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("capture_period_moving_average_tb passed");
    end else begin
      $display("capture_period_moving_average_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cpma_pkg.sv
sv/cpma_cdiv.sv
sv/capture_period_moving_average.sv
tb/sv/capture_period_moving_average_tb.sv
